/* sv/closest_point_on_triangle_macros.svh */
// Assertion macros for the closest point RTL, included by cpt_div
`ifndef CLOSEST_POINT_ON_TRIANGLE_MACROS_SVH
`define CLOSEST_POINT_ON_TRIANGLE_MACROS_SVH

// Clocked on i_clk, disabled while i_rst_n is low
`define CPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Same-cycle implication
`define CPT_ASSERT_IMP(lbl, pre, post, msg) `CPT_ASSERT(lbl, (pre) |-> (post), msg)

// Next-cycle implication
`define CPT_ASSERT_NXT(lbl, pre, post, msg) `CPT_ASSERT(lbl, (pre) |=> (post), msg)

`endif

/* sv/cpt_pkg.sv */
// Types, widths and indices shared by the closest point pipeline
`default_nettype none
package cpt_pkg;

    localparam int CW    = 32;
    localparam int NAX   = 3;
    localparam int IN_TW = 4 * NAX * CW;
    localparam int OUT_TW = NAX * CW;

    localparam int DFW = CW + 1;
    localparam int PW  = 2 * DFW;
    localparam int DTW = PW + 2;
    localparam int HW  = DTW / 2;
    localparam int EW  = DTW + 1;
    localparam int PRW = 2 * DTW;
    localparam int VW  = PRW + 1;
    localparam int DW  = VW + 2;
    localparam int WC  = 28;
    localparam int NCH = 5;
    localparam int WXW = WC * NCH;
    localparam int CKW = WC + 1;
    localparam int PPW = DFW + CKW;
    localparam int NW  = DFW + VW + 1;
    localparam int QB  = 35;
    localparam int SW  = DW + QB;
    localparam int RQW = QB + 1;
    localparam int OW  = RQW + 2;

    localparam int D1 = 0;
    localparam int D2 = 1;
    localparam int D3 = 2;
    localparam int D4 = 3;
    localparam int D5 = 4;
    localparam int D6 = 5;
    localparam int ND = 6;

    typedef logic signed [CW-1:0]  t_crd;
    typedef logic signed [DFW-1:0] t_dif;
    typedef logic signed [PW-1:0]  t_prd;
    typedef logic signed [DTW-1:0] t_dot;
    typedef logic signed [EW-1:0]  t_edg;
    typedef logic signed [VW-1:0]  t_vab;
    typedef logic signed [DW-1:0]  t_den;
    typedef logic signed [NW-1:0]  t_num;

    localparam t_crd CRD_MAX = t_crd'({1'b0, {(CW-1){1'b1}}});
    localparam t_crd CRD_MIN = t_crd'({1'b1, {(CW-1){1'b0}}});

    typedef struct {
        t_crd p [NAX];
        t_crd a [NAX];
        t_crd b [NAX];
        t_crd c [NAX];
    } t_pts;

    typedef struct {
        t_crd a  [NAX];
        t_crd b  [NAX];
        t_crd c  [NAX];
        t_dif ab [NAX];
        t_dif ac [NAX];
        t_dif bc [NAX];
        t_dot d  [ND];
    } t_dots;

    typedef struct {
        t_crd bs [NAX];
        t_dif m1 [NAX];
        t_dif m2 [NAX];
        t_vab w1;
        t_vab w2;
        t_den den;
    } t_geo;

    typedef struct {
        t_crd bs  [NAX];
        t_num num [NAX];
        t_den den;
    } t_frac;

endpackage
`default_nettype wire

/* sv/cpt_dot.sv */
// Edge vectors and the six dot products, three stages
`default_nettype none
module cpt_dot (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  cpt_pkg::t_pts  i_pts,
    output logic           o_vld,
    output cpt_pkg::t_dots o_dots
);
    import cpt_pkg::*;

    t_crd  r1_a [NAX];
    t_crd  r1_b [NAX];
    t_crd  r1_c [NAX];
    t_dif  r1_ab [NAX];
    t_dif  r1_ac [NAX];
    t_dif  r1_bc [NAX];
    t_dif  r1_ap [NAX];
    t_dif  r1_bp [NAX];
    t_dif  r1_cp [NAX];
    t_crd  r2_a [NAX];
    t_crd  r2_b [NAX];
    t_crd  r2_c [NAX];
    t_dif  r2_ab [NAX];
    t_dif  r2_ac [NAX];
    t_dif  r2_bc [NAX];
    t_prd  r2_pd [ND][NAX];
    t_dots r3_dt;
    logic  r1_v, r2_v, r3_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_vld;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int ax = 0; ax < NAX; ax++) begin
                r1_a[ax]  <= i_pts.a[ax];
                r1_b[ax]  <= i_pts.b[ax];
                r1_c[ax]  <= i_pts.c[ax];
                r1_ab[ax] <= DFW'(i_pts.b[ax]) - DFW'(i_pts.a[ax]);
                r1_ac[ax] <= DFW'(i_pts.c[ax]) - DFW'(i_pts.a[ax]);
                r1_bc[ax] <= DFW'(i_pts.c[ax]) - DFW'(i_pts.b[ax]);
                r1_ap[ax] <= DFW'(i_pts.p[ax]) - DFW'(i_pts.a[ax]);
                r1_bp[ax] <= DFW'(i_pts.p[ax]) - DFW'(i_pts.b[ax]);
                r1_cp[ax] <= DFW'(i_pts.p[ax]) - DFW'(i_pts.c[ax]);

                r2_a[ax]  <= r1_a[ax];
                r2_b[ax]  <= r1_b[ax];
                r2_c[ax]  <= r1_c[ax];
                r2_ab[ax] <= r1_ab[ax];
                r2_ac[ax] <= r1_ac[ax];
                r2_bc[ax] <= r1_bc[ax];
                r2_pd[D1][ax] <= r1_ab[ax] * r1_ap[ax];
                r2_pd[D2][ax] <= r1_ac[ax] * r1_ap[ax];
                r2_pd[D3][ax] <= r1_ab[ax] * r1_bp[ax];
                r2_pd[D4][ax] <= r1_ac[ax] * r1_bp[ax];
                r2_pd[D5][ax] <= r1_ab[ax] * r1_cp[ax];
                r2_pd[D6][ax] <= r1_ac[ax] * r1_cp[ax];

                r3_dt.a[ax]  <= r2_a[ax];
                r3_dt.b[ax]  <= r2_b[ax];
                r3_dt.c[ax]  <= r2_c[ax];
                r3_dt.ab[ax] <= r2_ab[ax];
                r3_dt.ac[ax] <= r2_ac[ax];
                r3_dt.bc[ax] <= r2_bc[ax];
            end
            for (int j = 0; j < ND; j++) begin
                r3_dt.d[j] <= DTW'(r2_pd[j][0]) + DTW'(r2_pd[j][1]) + DTW'(r2_pd[j][2]);
            end
        end
    end

    assign o_vld  = r3_v;
    assign o_dots = r3_dt;

endmodule
`default_nettype wire

/* sv/cpt_reg.sv */
// Cross terms, region decision and selection of base, numerator factors and divisor
`default_nettype none
module cpt_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  cpt_pkg::t_dots i_dots,
    output logic           o_vld,
    output cpt_pkg::t_geo  o_geo
);
    import cpt_pkg::*;

    typedef struct {
        t_crd a  [NAX];
        t_crd b  [NAX];
        t_crd c  [NAX];
        t_dif ab [NAX];
        t_dif ac [NAX];
        t_dif bc [NAX];
        t_dot d1;
        t_dot d2;
        t_edg e1;
        t_edg e2;
        t_edg dab;
        t_edg dac;
        logic fa;
        logic fb;
        logic fc;
        logic d1ge;
        logic d3le;
        logic d2ge;
        logic d6le;
    } t_side;

    localparam int NP = 6;
    localparam int PX [NP] = '{D1, D3, D5, D1, D3, D5};
    localparam int PY [NP] = '{D4, D2, D2, D6, D6, D4};

    t_side n_sd, r4_sd, r5_sd, r6_sd;
    logic signed [DTW-1:0] r4_hh [NP];
    logic signed [EW-1:0]  r4_hl [NP];
    logic signed [EW-1:0]  r4_lh [NP];
    logic [DTW-1:0]        r4_ll [NP];
    logic signed [PRW-1:0] r5_p [NP];
    t_vab r6_va, r6_vb, r6_vc;
    t_geo n_geo, r7_geo;
    logic r4_v, r5_v, r6_v, r7_v;
    logic ab_edge, ac_edge, bc_edge;

    always_comb begin
        n_sd.a   = i_dots.a;
        n_sd.b   = i_dots.b;
        n_sd.c   = i_dots.c;
        n_sd.ab  = i_dots.ab;
        n_sd.ac  = i_dots.ac;
        n_sd.bc  = i_dots.bc;
        n_sd.d1  = i_dots.d[D1];
        n_sd.d2  = i_dots.d[D2];
        n_sd.e1  = EW'(i_dots.d[D4]) - EW'(i_dots.d[D3]);
        n_sd.e2  = EW'(i_dots.d[D5]) - EW'(i_dots.d[D6]);
        n_sd.dab = EW'(i_dots.d[D1]) - EW'(i_dots.d[D3]);
        n_sd.dac = EW'(i_dots.d[D2]) - EW'(i_dots.d[D6]);
        n_sd.fa  = (i_dots.d[D1][DTW-1] || i_dots.d[D1] == '0)
                && (i_dots.d[D2][DTW-1] || i_dots.d[D2] == '0);
        n_sd.fb  = !i_dots.d[D3][DTW-1] && (n_sd.e1[EW-1] || n_sd.e1 == '0);
        n_sd.fc  = !i_dots.d[D6][DTW-1] && (n_sd.e2[EW-1] || n_sd.e2 == '0);
        n_sd.d1ge = !i_dots.d[D1][DTW-1];
        n_sd.d3le = i_dots.d[D3][DTW-1] || i_dots.d[D3] == '0;
        n_sd.d2ge = !i_dots.d[D2][DTW-1];
        n_sd.d6le = i_dots.d[D6][DTW-1] || i_dots.d[D6] == '0;
    end

    assign ab_edge = (r6_vc[VW-1] || r6_vc == '0) && r6_sd.d1ge && r6_sd.d3le;
    assign ac_edge = (r6_vb[VW-1] || r6_vb == '0) && r6_sd.d2ge && r6_sd.d6le;
    assign bc_edge = (r6_va[VW-1] || r6_va == '0) && !r6_sd.e1[EW-1] && !r6_sd.e2[EW-1];

    always_comb begin
        for (int ax = 0; ax < NAX; ax++) begin
            n_geo.bs[ax] = r6_sd.a[ax];
            n_geo.m1[ax] = '0;
            n_geo.m2[ax] = '0;
        end
        n_geo.w1  = '0;
        n_geo.w2  = '0;
        n_geo.den = '0;
        if (r6_sd.fa) begin
            n_geo.den = '0;
        end else if (r6_sd.fb) begin
            for (int ax = 0; ax < NAX; ax++) n_geo.bs[ax] = r6_sd.b[ax];
        end else if (ab_edge) begin
            for (int ax = 0; ax < NAX; ax++) n_geo.m1[ax] = r6_sd.ab[ax];
            n_geo.w1  = VW'(r6_sd.d1);
            n_geo.den = DW'(r6_sd.dab);
        end else if (r6_sd.fc) begin
            for (int ax = 0; ax < NAX; ax++) n_geo.bs[ax] = r6_sd.c[ax];
        end else if (ac_edge) begin
            for (int ax = 0; ax < NAX; ax++) n_geo.m1[ax] = r6_sd.ac[ax];
            n_geo.w1  = VW'(r6_sd.d2);
            n_geo.den = DW'(r6_sd.dac);
        end else if (bc_edge) begin
            for (int ax = 0; ax < NAX; ax++) begin
                n_geo.bs[ax] = r6_sd.b[ax];
                n_geo.m1[ax] = r6_sd.bc[ax];
            end
            n_geo.w1  = VW'(r6_sd.e1);
            n_geo.den = DW'(r6_sd.e1) + DW'(r6_sd.e2);
        end else begin
            for (int ax = 0; ax < NAX; ax++) begin
                n_geo.m1[ax] = r6_sd.ab[ax];
                n_geo.m2[ax] = r6_sd.ac[ax];
            end
            n_geo.w1  = r6_vb;
            n_geo.w2  = r6_vc;
            n_geo.den = DW'(r6_va) + DW'(r6_vb) + DW'(r6_vc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (i_en) begin
            r4_v <= i_vld;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_sd <= n_sd;
            for (int q = 0; q < NP; q++) begin
                r4_hh[q] <= $signed(i_dots.d[PX[q]][DTW-1:HW])
                          * $signed(i_dots.d[PY[q]][DTW-1:HW]);
                r4_hl[q] <= $signed(i_dots.d[PX[q]][DTW-1:HW])
                          * $signed({1'b0, i_dots.d[PY[q]][HW-1:0]});
                r4_lh[q] <= $signed({1'b0, i_dots.d[PX[q]][HW-1:0]})
                          * $signed(i_dots.d[PY[q]][DTW-1:HW]);
                r4_ll[q] <= i_dots.d[PX[q]][HW-1:0] * i_dots.d[PY[q]][HW-1:0];
                r5_p[q]  <= (PRW'(r4_hh[q]) <<< (2 * HW)) + (PRW'(r4_hl[q]) <<< HW)
                          + (PRW'(r4_lh[q]) <<< HW) + PRW'(r4_ll[q]);
            end
            r5_sd  <= r4_sd;
            r6_sd  <= r5_sd;
            r6_vc  <= VW'(r5_p[0]) - VW'(r5_p[1]);
            r6_vb  <= VW'(r5_p[2]) - VW'(r5_p[3]);
            r6_va  <= VW'(r5_p[4]) - VW'(r5_p[5]);
            r7_geo <= n_geo;
        end
    end

    assign o_vld = r7_v;
    assign o_geo = r7_geo;

endmodule
`default_nettype wire

/* sv/cpt_num.sv */
// Numerator per axis from chunked partial products, three stages
`default_nettype none
module cpt_num (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  cpt_pkg::t_geo  i_geo,
    output logic           o_vld,
    output cpt_pkg::t_frac o_frac
);
    import cpt_pkg::*;

    logic signed [WXW-1:0] n_wx [2];
    logic signed [CKW-1:0] n_ck [2][NCH];
    logic signed [PPW-1:0] r8_pp [NAX][2][NCH];
    t_crd  r8_bs [NAX];
    t_den  r8_den;
    t_num  r9_t [NAX][2];
    t_crd  r9_bs [NAX];
    t_den  r9_den;
    t_frac r10_fr;
    logic  r8_v, r9_v, r10_v;

    always_comb begin
        n_wx[0] = WXW'(i_geo.w1);
        n_wx[1] = WXW'(i_geo.w2);
        for (int t = 0; t < 2; t++) begin
            for (int k = 0; k < NCH; k++) begin
                n_ck[t][k] = $signed({(k == NCH - 1) ? n_wx[t][WXW-1] : 1'b0,
                                      n_wx[t][WC*k +: WC]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v  <= 1'b0;
            r9_v  <= 1'b0;
            r10_v <= 1'b0;
        end else if (i_en) begin
            r8_v  <= i_vld;
            r9_v  <= r8_v;
            r10_v <= r9_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r8_bs  <= i_geo.bs;
            r8_den <= i_geo.den;
            r9_bs  <= r8_bs;
            r9_den <= r8_den;
            r10_fr.bs  <= r9_bs;
            r10_fr.den <= r9_den;
            for (int ax = 0; ax < NAX; ax++) begin
                for (int k = 0; k < NCH; k++) begin
                    r8_pp[ax][0][k] <= i_geo.m1[ax] * n_ck[0][k];
                    r8_pp[ax][1][k] <= i_geo.m2[ax] * n_ck[1][k];
                end
                for (int t = 0; t < 2; t++) begin
                    r9_t[ax][t] <= NW'(r8_pp[ax][t][0])
                                 + (NW'(r8_pp[ax][t][1]) <<< WC)
                                 + (NW'(r8_pp[ax][t][2]) <<< (2 * WC))
                                 + (NW'(r8_pp[ax][t][3]) <<< (3 * WC))
                                 + (NW'(r8_pp[ax][t][4]) <<< (4 * WC));
                end
                r10_fr.num[ax] <= r9_t[ax][0] + r9_t[ax][1];
            end
        end
    end

    assign o_vld  = r10_v;
    assign o_frac = r10_fr;

endmodule
`default_nettype wire

/* sv/cpt_div.sv */
// Restoring divider per axis, rounding, offset add and saturation
`default_nettype none
`include "closest_point_on_triangle_macros.svh"
module cpt_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  cpt_pkg::t_frac i_frac,
    output logic           o_vld,
    output cpt_pkg::t_crd  o_near [cpt_pkg::NAX]
);
    import cpt_pkg::*;

    logic [NW-1:0]  r11_nm [NAX];
    logic [DW-1:0]  r11_dm;
    logic           r11_sg [NAX];
    logic           r11_dz;
    t_crd           r11_bs [NAX];
    logic           r11_v;

    logic [NW-1:0]  r_rem [QB+1][NAX];
    logic [QB-1:0]  r_q   [QB+1][NAX];
    logic           r_sg  [QB+1][NAX];
    logic           r_ov  [QB+1][NAX];
    t_crd           r_bs  [QB+1][NAX];
    logic [DW-1:0]  r_dm  [QB+1];
    logic           r_dz  [QB+1];
    logic           r_v   [QB+1];
    logic [SW:0]    n_sub [QB][NAX];

    logic [RQW-1:0] r_rq  [NAX];
    logic           r_rsg [NAX];
    logic           r_rov [NAX];
    t_crd           r_rbs [NAX];
    logic           r_rdz;
    logic           r_rv;

    logic signed [OW-1:0] n_off [NAX];
    logic signed [OW-1:0] n_sm  [NAX];
    t_crd                 n_out [NAX];
    t_crd                 r_out [NAX];
    logic                 r_ov_v;

    always_comb begin
        for (int s = 0; s < QB; s++) begin
            for (int ax = 0; ax < NAX; ax++) begin
                n_sub[s][ax] = {1'b0, SW'(r_rem[s][ax])}
                             - {1'b0, (SW'(r_dm[s]) << (QB - 1 - s))};
            end
        end
    end

    always_comb begin
        for (int ax = 0; ax < NAX; ax++) begin
            n_off[ax] = r_rsg[ax] ? (OW'(0) - OW'(r_rq[ax])) : OW'(r_rq[ax]);
            n_sm[ax]  = OW'(r_rbs[ax]) + n_off[ax];
            if (r_rdz) begin
                n_out[ax] = r_rbs[ax];
            end else if (r_rov[ax]) begin
                n_out[ax] = r_rsg[ax] ? CRD_MIN : CRD_MAX;
            end else if (n_sm[ax][OW-1:CW-1] == '0 || n_sm[ax][OW-1:CW-1] == '1) begin
                n_out[ax] = n_sm[ax][CW-1:0];
            end else begin
                n_out[ax] = n_sm[ax][OW-1] ? CRD_MIN : CRD_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_v  <= 1'b0;
            r_rv   <= 1'b0;
            r_ov_v <= 1'b0;
            for (int s = 0; s <= QB; s++) r_v[s] <= 1'b0;
        end else if (i_en) begin
            r11_v  <= i_vld;
            r_v[0] <= r11_v;
            for (int s = 0; s < QB; s++) r_v[s+1] <= r_v[s];
            r_rv   <= r_v[QB];
            r_ov_v <= r_rv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r11_dm <= i_frac.den[DW-1] ? (~i_frac.den + 1'b1) : i_frac.den;
            r11_dz <= (i_frac.den == '0);
            for (int ax = 0; ax < NAX; ax++) begin
                r11_nm[ax] <= i_frac.num[ax][NW-1] ? (~i_frac.num[ax] + 1'b1) : i_frac.num[ax];
                r11_sg[ax] <= i_frac.num[ax][NW-1] ^ i_frac.den[DW-1];
                r11_bs[ax] <= i_frac.bs[ax];
            end

            r_dm[0] <= r11_dm;
            r_dz[0] <= r11_dz;
            for (int ax = 0; ax < NAX; ax++) begin
                r_rem[0][ax] <= r11_nm[ax];
                r_q[0][ax]   <= '0;
                r_sg[0][ax]  <= r11_sg[ax];
                r_bs[0][ax]  <= r11_bs[ax];
                r_ov[0][ax]  <= SW'(r11_nm[ax]) >= {r11_dm, {QB{1'b0}}};
            end

            for (int s = 0; s < QB; s++) begin
                r_dm[s+1] <= r_dm[s];
                r_dz[s+1] <= r_dz[s];
                for (int ax = 0; ax < NAX; ax++) begin
                    r_sg[s+1][ax] <= r_sg[s][ax];
                    r_ov[s+1][ax] <= r_ov[s][ax];
                    r_bs[s+1][ax] <= r_bs[s][ax];
                    if (n_sub[s][ax][SW]) begin
                        r_rem[s+1][ax] <= r_rem[s][ax];
                        r_q[s+1][ax]   <= r_q[s][ax];
                    end else begin
                        r_rem[s+1][ax] <= n_sub[s][ax][NW-1:0];
                        r_q[s+1][ax]   <= r_q[s][ax] | (QB'(1) << (QB - 1 - s));
                    end
                end
            end

            r_rdz <= r_dz[QB];
            for (int ax = 0; ax < NAX; ax++) begin
                r_rq[ax]  <= RQW'(r_q[QB][ax])
                           + RQW'({r_rem[QB][ax][DW-1:0], 1'b0} >= {1'b0, r_dm[QB]});
                r_rsg[ax] <= r_sg[QB][ax];
                r_rov[ax] <= r_ov[QB][ax];
                r_rbs[ax] <= r_bs[QB][ax];
                r_out[ax] <= n_out[ax];
            end
        end
    end

    assign o_vld  = r_ov_v;
    assign o_near = r_out;

    `CPT_ASSERT_IMP(a_rem_below_div, r_v[QB] && !r_dz[QB] && !r_ov[QB][0], r_rem[QB][0] < NW'(r_dm[QB]), "remainder not below divisor")
    `CPT_ASSERT_IMP(a_quot_bound, r_rv && !r_rdz && !r_rov[0], r_rq[0] <= (RQW'(1) << QB), "rounded quotient out of range")
    `CPT_ASSERT_NXT(a_zero_div_base, r_rv && r_rdz && i_en, o_vld && r_out[0] == $past(r_rbs[0]), "zero divisor must give base vertex")

endmodule
`default_nettype wire

/* sv/closest_point_on_triangle.sv */
// Throughput: one beat per cycle; every stage advances together when the output register
// is empty or being taken, so master-side backpressure holds the whole pipeline.
// Depth is set by the 35-step restoring divider (one quotient bit per stage) and the
// split 68x68 and 33x137 multiplications. Reset clears the valid bits only.
`default_nettype none
module closest_point_on_triangle (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // query_x, query_y, query_z, vert_a_x..z, vert_b_x..z, vert_c_x..z
    input  logic [cpt_pkg::IN_TW-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // near_x, near_y, near_z
    output logic [cpt_pkg::OUT_TW-1:0] m_axis_tdata
);
    import cpt_pkg::*;

    logic  en;
    t_pts  pts;
    t_dots dots;
    t_geo  geo;
    t_frac frac;
    t_crd  near [NAX];
    logic  dot_v, reg_v, num_v;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_comb begin
        for (int ax = 0; ax < NAX; ax++) begin
            pts.p[ax] = s_axis_tdata[CW*ax +: CW];
            pts.a[ax] = s_axis_tdata[CW*(NAX+ax) +: CW];
            pts.b[ax] = s_axis_tdata[CW*(2*NAX+ax) +: CW];
            pts.c[ax] = s_axis_tdata[CW*(3*NAX+ax) +: CW];
        end
    end

    cpt_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (s_axis_tvalid),
        .i_pts   (pts),
        .o_vld   (dot_v),
        .o_dots  (dots)
    );

    cpt_reg u_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (dot_v),
        .i_dots  (dots),
        .o_vld   (reg_v),
        .o_geo   (geo)
    );

    cpt_num u_num (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (reg_v),
        .i_geo   (geo),
        .o_vld   (num_v),
        .o_frac  (frac)
    );

    cpt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (num_v),
        .i_frac  (frac),
        .o_vld   (m_axis_tvalid),
        .o_near  (near)
    );

    always_comb begin
        for (int ax = 0; ax < NAX; ax++) begin
            m_axis_tdata[CW*ax +: CW] = near[ax];
        end
    end

endmodule
`default_nettype wire

/* verif/closest_point_on_triangle_check.sv */
// Checker that predicts the nearest point for each input beat and compares result beats
module closest_point_on_triangle_check (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [cpt_pkg::IN_TW-1:0]  i_in_data,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [cpt_pkg::OUT_TW-1:0] i_out_data,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_result_count
);
    import cpt_pkg::*;

    typedef logic signed [255:0] t_big;

    logic [OUT_TW-1:0] near_points[$];

    function automatic t_big dot3(t_big ux, t_big uy, t_big uz, t_big vx, t_big vy, t_big vz);
        return ux * vx + uy * vy + uz * vz;
    endfunction

    // base plus the quotient rounded half away from zero, saturated to the coordinate range
    function automatic t_crd offset_round(t_big base, t_big num, t_big den);
        t_big an;
        t_big ad;
        t_big q;
        t_big s;
        q = 0;
        if (den != 0) begin
            an = (num < 0) ? -num : num;
            ad = (den < 0) ? -den : den;
            q = an / ad;
            if (((an % ad) <<< 1) >= ad) q = q + 1;
            if ((num < 0) != (den < 0)) q = -q;
        end
        s = base + q;
        if (s > t_big'(CRD_MAX)) return CRD_MAX;
        if (s < t_big'(CRD_MIN)) return CRD_MIN;
        return t_crd'(s);
    endfunction

    function automatic logic [OUT_TW-1:0] nearest_point(logic [IN_TW-1:0] beat);
        t_big p[3], a[3], b[3], c[3], ab[3], ac[3], bc[3], ap[3], bp[3], cp[3];
        t_big d1, d2, d3, d4, d5, d6, va, vb, vc, e1, e2;
        logic [OUT_TW-1:0] r;
        for (int i = 0; i < 3; i++) begin
            p[i] = $signed(beat[CW*i +: CW]);
            a[i] = $signed(beat[CW*(3+i) +: CW]);
            b[i] = $signed(beat[CW*(6+i) +: CW]);
            c[i] = $signed(beat[CW*(9+i) +: CW]);
            ab[i] = b[i] - a[i];
            ac[i] = c[i] - a[i];
            bc[i] = c[i] - b[i];
            ap[i] = p[i] - a[i];
            bp[i] = p[i] - b[i];
            cp[i] = p[i] - c[i];
        end
        d1 = dot3(ab[0], ab[1], ab[2], ap[0], ap[1], ap[2]);
        d2 = dot3(ac[0], ac[1], ac[2], ap[0], ap[1], ap[2]);
        d3 = dot3(ab[0], ab[1], ab[2], bp[0], bp[1], bp[2]);
        d4 = dot3(ac[0], ac[1], ac[2], bp[0], bp[1], bp[2]);
        d5 = dot3(ab[0], ab[1], ab[2], cp[0], cp[1], cp[2]);
        d6 = dot3(ac[0], ac[1], ac[2], cp[0], cp[1], cp[2]);
        vc = d1 * d4 - d3 * d2;
        vb = d5 * d2 - d1 * d6;
        va = d3 * d6 - d5 * d4;
        e1 = d4 - d3;
        e2 = d5 - d6;
        for (int i = 0; i < 3; i++) begin
            if (d1 <= 0 && d2 <= 0)
                r[CW*i +: CW] = t_crd'(a[i]);
            else if (d3 >= 0 && d4 - d3 <= 0)
                r[CW*i +: CW] = t_crd'(b[i]);
            else if (vc <= 0 && d1 >= 0 && d3 <= 0)
                r[CW*i +: CW] = offset_round(a[i], ab[i] * d1, d1 - d3);
            else if (d6 >= 0 && d5 - d6 <= 0)
                r[CW*i +: CW] = t_crd'(c[i]);
            else if (vb <= 0 && d2 >= 0 && d6 <= 0)
                r[CW*i +: CW] = offset_round(a[i], ac[i] * d2, d2 - d6);
            else if (va <= 0 && e1 >= 0 && e2 >= 0)
                r[CW*i +: CW] = offset_round(b[i], bc[i] * e1, e1 + e2);
            else
                r[CW*i +: CW] = offset_round(a[i], ab[i] * vb + ac[i] * vc, va + vb + vc);
        end
        return r;
    endfunction

    assign o_pending = near_points.size();

    always @(posedge i_clk) begin
        logic [OUT_TW-1:0] want;
        if (!i_rst_n) begin
            o_fail_count = 0;
            o_result_count = 0;
        end else begin
            if (i_in_valid && i_in_ready) near_points.push_back(nearest_point(i_in_data));
            if (i_out_valid && i_out_ready) begin
                o_result_count++;
                if (near_points.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result beat %h", i_out_data);
                end else begin
                    want = near_points.pop_front();
                    for (int i = 0; i < 3; i++)
                        if (want[CW*i +: CW] !== i_out_data[CW*i +: CW]) begin
                            o_fail_count++;
                            if (o_fail_count <= 10)
                                $display("near axis %0d: expected %h, got %h (beat %0d)",
                                         i, want[CW*i +: CW], i_out_data[CW*i +: CW],
                                         o_result_count);
                        end
                end
            end
        end
    end
endmodule

/* verif/closest_point_on_triangle_test.sv */
// Testbench top: drives triangle queries, stalls the result side, reports the verdict
module closest_point_on_triangle_test;
    import cpt_pkg::*;

    localparam int LIMIT = 200000;
    localparam int U = 65536;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_TW-1:0]  s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_TW-1:0] m_axis_tdata;
    int                fail_count;
    int                pending;
    int                result_count;
    int                cycles = 0;
    int                sent = 0;
    bit                burst = 0;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    closest_point_on_triangle dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    closest_point_on_triangle_check check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready), .i_out_data(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    // take results, holding ready low for a random count before each beat
    initial begin
        int hold;
        @(posedge i_rst_n);
        forever begin
            hold = burst ? 0 : $urandom_range(0, 8);
            @(negedge i_clk);
            if (hold > 0) begin
                m_axis_tready = 1'b0;
                repeat (hold - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    task automatic send_beat(input t_crd v[12]);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 8);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        for (int i = 0; i < 12; i++) s_axis_tdata[CW*i +: CW] = v[i];
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_scaled(input int px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz);
        t_crd v[12];
        v = '{px*U, py*U, pz*U, ax*U, ay*U, az*U, bx*U, by*U, bz*U, cx*U, cy*U, cz*U};
        send_beat(v);
    endtask

    function automatic t_crd near_to(t_crd centre, int span);
        return t_crd'(centre + $signed($urandom_range(0, 2*span)) - span);
    endfunction

    initial begin
        t_crd v[12];
        t_crd centre;
        int span;
        int kind;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // regions of a right triangle in the xy plane
        send_scaled(-1, -1, 5,  0, 0, 0, 10, 0, 0, 0, 10, 0);
        send_scaled(12, -1, 2,  0, 0, 0, 10, 0, 0, 0, 10, 0);
        send_scaled(-1, 12, -3, 0, 0, 0, 10, 0, 0, 0, 10, 0);
        send_scaled(5, -3, 1,   0, 0, 0, 10, 0, 0, 0, 10, 0);
        send_scaled(-3, 5, 1,   0, 0, 0, 10, 0, 0, 0, 10, 0);
        send_scaled(6, 6, -2,   0, 0, 0, 10, 0, 0, 0, 10, 0);
        send_scaled(2, 3, 7,    0, 0, 0, 10, 0, 0, 0, 10, 0);
        send_scaled(0, 0, 0,    0, 0, 0, 10, 0, 0, 0, 10, 0);
        send_scaled(10, 0, 0,   0, 0, 0, 10, 0, 0, 0, 10, 0);
        send_scaled(1, 1, 1,    3, 3, 3, 10, 7, 1, -4, 2, 9);
        // degenerate: single point, coincident pair, collinear
        send_scaled(4, 5, 6,    1, 1, 1, 1, 1, 1, 1, 1, 1);
        send_scaled(4, 5, 6,    1, 1, 1, 1, 1, 1, 7, 2, 3);
        send_scaled(3, 9, -2,   0, 0, 0, 2, 2, 2, 5, 5, 5);
        send_scaled(2, 2, 1,    0, 0, 0, 4, 4, 0, 2, 2, 0);
        // coordinate extremes
        v = '{CRD_MIN, CRD_MIN, CRD_MIN, CRD_MAX, CRD_MAX, CRD_MAX,
              CRD_MIN, CRD_MAX, 0, 0, CRD_MIN, CRD_MAX};
        send_beat(v);
        v = '{CRD_MAX, CRD_MAX, CRD_MAX, CRD_MIN, CRD_MIN, CRD_MIN,
              CRD_MAX, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MAX, CRD_MIN};
        send_beat(v);
        v = '{0, 0, CRD_MAX, CRD_MIN, CRD_MAX, 0, CRD_MAX, CRD_MAX, 0,
              CRD_MIN, CRD_MIN, 0};
        send_beat(v);
        v = '{CRD_MAX, CRD_MIN, 0, CRD_MIN, CRD_MIN, CRD_MIN,
              CRD_MAX, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MAX, CRD_MAX};
        send_beat(v);
        v = '{-1, 1, -1, 0, 0, 0, 1, 0, 0, 0, 1, 0};
        send_beat(v);

        for (int n = 0; n < 700; n++) begin
            if (n % 100 == 0) burst = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
                for (int i = 0; i < 12; i++) v[i] = $urandom;
            end else begin
                centre = $urandom;
                span = (kind < 5) ? (1 << $urandom_range(4, 30)) : (1 << $urandom_range(2, 24));
                for (int i = 0; i < 12; i++) v[i] = near_to(centre, span);
                if (kind == 9) begin
                    // repeat vertices: b copies a, and c sometimes copies a too
                    for (int i = 0; i < 3; i++) v[6+i] = v[3+i];
                    if ($urandom_range(0, 1)) for (int i = 0; i < 3; i++) v[9+i] = v[3+i];
                end else if (kind == 8) begin
                    // query near the triangle's centroid, offset by up to 32 on each axis
                    for (int i = 0; i < 3; i++)
                        v[i] = t_crd'((v[3+i] + v[6+i] + v[9+i]) / 3
                                      + $signed($urandom_range(0, 64)) - 32);
                end
            end
            send_beat(v);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        burst = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("%0d triangle queries sent, %0d nearest points checked", sent, result_count);
        $display("covered vertex, edge and face regions, degenerate and extreme triangles");
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
